[rtl/traffic_signal_lane_arbiter_top_assert.svh]
// assertion macros for the lane arbiter checker
// expects clk_i and rst_ni in the scope of each use
`ifndef TRAFFIC_SIGNAL_LANE_ARBITER_TOP_ASSERT_SVH
`define TRAFFIC_SIGNAL_LANE_ARBITER_TOP_ASSERT_SVH

// same-cycle implication
`define TSLA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lane arbiter assertion failed");

// next-cycle implication
`define TSLA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lane arbiter assertion failed");

`endif

[rtl/tsla_pkg.sv]
// shared types and constants for the traffic signal lane arbiter
// no dependencies
`default_nettype none

package tsla_pkg;

  localparam int QueueDepth = 32;
  localparam int LaneCount  = 4;

  localparam int CountW  = $clog2(QueueDepth + 1);
  localparam int SlotW   = $clog2(QueueDepth);
  localparam int LaneW   = $clog2(LaneCount);
  localparam int AgeW    = 8;
  localparam int ScoreW  = 9;
  localparam int BiasW   = 4;
  localparam int ShiftW  = 3;
  localparam int DrainW  = 6;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 6;

  localparam logic [AgeW-1:0]   AgeMax     = {AgeW{1'b1}};
  localparam logic [BiasW-1:0]  BiasReset  = BiasW'(3);
  localparam logic [ShiftW-1:0] ShiftReset = ShiftW'(1);
  localparam logic [DrainW-1:0] DrainReset = DrainW'(1);

  typedef enum logic [1:0] {
    CmdArrive = 2'd0,
    CmdDecide = 2'd1,
    CmdPass   = 2'd2,
    CmdRsvd   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    OutAdded     = 3'd0,
    OutDropped   = 3'd1,
    OutPassed    = 3'd2,
    OutNoPass    = 3'd3,
    OutOverride  = 3'd4,
    OutHold      = 3'd5,
    OutSwitched  = 3'd6,
    OutContinued = 3'd7
  } outcome_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgBias  = 2'd0,
    CfgShift = 2'd1,
    CfgDrain = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [BiasW-1:0]  bias;
    logic [ShiftW-1:0] shift;
    logic [DrainW-1:0] drain;
  } cfg_t;

  typedef struct packed {
    cmd_e       command;
    logic [1:0] lane;
    logic       is_ambulance;
  } item_t;

  typedef struct packed {
    logic [LaneCount-1:0][CountW-1:0]     count;
    logic [LaneCount-1:0][QueueDepth-1:0] slots;
    logic [LaneCount-1:0][AgeW-1:0]       age;
    logic [LaneW-1:0]                     green;
    logic [CountW-1:0]                    start;
  } state_t;

  typedef struct packed {
    logic [1:0]  green_lane;
    outcome_e    outcome;
    logic [8:0]  best_score;
    logic [5:0]  green_count;
    logic        ambulance_waiting;
  } result_t;

endpackage

`default_nettype wire

[rtl/tsla_arbiter.sv]
// highest-score lane pick, ties to the lowest index
// depends on tsla_pkg
`default_nettype none

module tsla_arbiter (
  input  logic [tsla_pkg::LaneCount-1:0][tsla_pkg::ScoreW-1:0] score_i,
  output logic [tsla_pkg::LaneW-1:0]                           win_o,
  output logic [tsla_pkg::ScoreW-1:0]                          best_o
);
  import tsla_pkg::*;

  always_comb begin
    best_o = score_i[0];
    win_o  = '0;
    for (int i = 1; i < LaneCount; i++) begin
      if (score_i[i] > best_o) begin
        best_o = score_i[i];
        win_o  = LaneW'(i);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/tsla_step.sv]
// next-state and result logic for one transaction
// depends on tsla_pkg and tsla_arbiter
`default_nettype none

module tsla_step (
  input  tsla_pkg::state_t  state_i,
  input  tsla_pkg::item_t   item_i,
  input  tsla_pkg::cfg_t    cfg_i,
  output tsla_pkg::state_t  state_o,
  output tsla_pkg::result_t result_o
);
  import tsla_pkg::*;

  logic [LaneCount-1:0][AgeW-1:0]   aged;
  logic [LaneCount-1:0][ScoreW-1:0] score;
  logic [LaneW-1:0]                 win;
  logic [ScoreW-1:0]                best;
  logic [LaneW-1:0]                 lane_idx;
  logic [LaneW-1:0]                 amb_lane;
  logic                             amb_any;
  logic [CountW-1:0]                green_cnt;
  logic [ScoreW-1:0]                bias;
  logic                             hold;

  assign lane_idx  = LaneW'(item_i.lane);
  assign green_cnt = state_i.count[state_i.green];
  assign bias      = (green_cnt != '0) ? ScoreW'(cfg_i.bias) : '0;
  assign hold      = (state_i.start > cfg_i.drain) &&
                     (green_cnt > (state_i.start >> 1));

  // aged starvation feeds the scores of the same decide
  always_comb begin
    for (int i = 0; i < LaneCount; i++) begin
      if (LaneW'(i) == state_i.green) begin
        aged[i] = '0;
      end else if (state_i.count[i] != '0 && state_i.age[i] != AgeMax) begin
        aged[i] = state_i.age[i] + AgeW'(1);
      end else begin
        aged[i] = state_i.age[i];
      end
      score[i] = ScoreW'(state_i.count[i]) + ScoreW'(aged[i] >> cfg_i.shift) +
                 ((LaneW'(i) == state_i.green) ? bias : ScoreW'(0));
    end
  end

  // lowest lane holding an ambulance
  always_comb begin
    amb_any  = 1'b0;
    amb_lane = '0;
    for (int i = LaneCount - 1; i >= 0; i--) begin
      if (state_i.slots[i] != '0) begin
        amb_any  = 1'b1;
        amb_lane = LaneW'(i);
      end
    end
  end

  tsla_arbiter u_arbiter (
    .score_i (score),
    .win_o   (win),
    .best_o  (best)
  );

  always_comb begin
    state_o             = state_i;
    result_o.outcome    = OutNoPass;
    result_o.best_score = '0;
    case (item_i.command)
      CmdArrive: begin
        if (32'(item_i.lane) >= LaneCount ||
            state_i.count[lane_idx] >= CountW'(QueueDepth)) begin
          result_o.outcome = OutDropped;
        end else begin
          if (item_i.is_ambulance) begin
            state_o.slots[lane_idx][SlotW'(state_i.count[lane_idx])] = 1'b1;
          end
          state_o.count[lane_idx] = state_i.count[lane_idx] + CountW'(1);
          result_o.outcome = OutAdded;
        end
      end
      CmdDecide: begin
        if (amb_any) begin
          state_o.green    = amb_lane;
          state_o.start    = state_i.count[amb_lane];
          result_o.outcome = OutOverride;
        end else if (hold) begin
          result_o.outcome = OutHold;
        end else begin
          state_o.age         = aged;
          result_o.best_score = best;
          if (win != state_i.green) begin
            state_o.green    = win;
            state_o.start    = state_i.count[win];
            result_o.outcome = OutSwitched;
          end else begin
            result_o.outcome = OutContinued;
          end
        end
      end
      CmdPass: begin
        if (green_cnt != '0) begin
          state_o.slots[state_i.green] = state_i.slots[state_i.green] >> 1;
          state_o.count[state_i.green] = green_cnt - CountW'(1);
          result_o.outcome = OutPassed;
        end
      end
      default: ;
    endcase
    result_o.green_lane        = 2'(state_o.green);
    result_o.green_count       = 6'(state_o.count[state_o.green]);
    result_o.ambulance_waiting = |state_o.slots;
  end

endmodule

`default_nettype wire

[rtl/traffic_signal_lane_arbiter_top.sv]
// Four-lane traffic signal arbiter. Takes one transaction per clock cycle while the output
// register is not stalled; the result is presented from the output register: a transaction
// lands in the input register, the lane state and the signal rule are evaluated in one
// combinational step, and the result is captured in the output register while the lane
// state updates in the same edge. Throughput is set by that single step over four lanes; a
// stalled output register holds the input register, and the input stalls only while both
// are full. Configuration writes take effect at the next edge and must be done while no
// transaction is in flight. No clearing pass is needed after reset.
`default_nettype none

module traffic_signal_lane_arbiter_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tsla_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [tsla_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     command_i,
  input  logic [1:0]                     lane_i,
  input  logic                           is_ambulance_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     green_lane_o,
  output logic [2:0]                     outcome_o,
  output logic [8:0]                     best_score_o,
  output logic [5:0]                     green_count_o,
  output logic                           ambulance_waiting_o
);
  import tsla_pkg::*;

  cfg_t    cfg_q;
  item_t   item_q;
  logic    item_valid_q;
  state_t  state_q;
  state_t  state_d;
  result_t result_d;
  result_t result_q;
  logic    out_valid_q;
  logic    out_free;
  logic    advance;
  logic    in_take;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = item_valid_q && out_free;
  assign in_stall_o = item_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bias  <= BiasReset;
      cfg_q.shift <= ShiftReset;
      cfg_q.drain <= DrainReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgBias:  cfg_q.bias  <= cfg_data_i[BiasW-1:0];
        CfgShift: cfg_q.shift <= cfg_data_i[ShiftW-1:0];
        CfgDrain: cfg_q.drain <= cfg_data_i[DrainW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_take) begin
      item_valid_q <= 1'b1;
    end else if (advance) begin
      item_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.command      <= cmd_e'(command_i);
      item_q.lane         <= lane_i;
      item_q.is_ambulance <= is_ambulance_i;
    end
  end

  tsla_step u_step (
    .state_i  (state_q),
    .item_i   (item_q),
    .cfg_i    (cfg_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign green_lane_o        = result_q.green_lane;
  assign outcome_o           = result_q.outcome;
  assign best_score_o        = result_q.best_score;
  assign green_count_o       = result_q.green_count;
  assign ambulance_waiting_o = result_q.ambulance_waiting;

endmodule

`default_nettype wire

[rtl/tsla_checker.sv]
// port-level checks for the lane arbiter top, bound to it below
// depends on tsla_pkg and traffic_signal_lane_arbiter_top_assert.svh
`default_nettype none

`include "traffic_signal_lane_arbiter_top_assert.svh"

module tsla_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [1:0] green_lane_o,
  input wire logic [2:0] outcome_o,
  input wire logic [8:0] best_score_o,
  input wire logic [5:0] green_count_o,
  input wire logic       ambulance_waiting_o
);
  import tsla_pkg::*;

  logic [20:0] out_payload;
  logic        greedy_out;
  logic        override_out;
  logic        count_in_range;

  assign out_payload    = {green_lane_o, outcome_o, best_score_o, green_count_o,
                           ambulance_waiting_o};
  assign greedy_out     = (outcome_o == OutSwitched) || (outcome_o == OutContinued);
  assign override_out   = (outcome_o == OutOverride);
  assign count_in_range = 32'(green_count_o) <= QueueDepth;

  // a held result transaction keeps its payload
  `TSLA_ASSERT_NEXT(a_out_held, out_valid_o && out_stall_i, out_valid_o && $stable(out_payload))

  // with the output register empty the input register always drains
  `TSLA_ASSERT_IMPL(a_no_stall_when_empty, !out_valid_o, !in_stall_o)

  // only a greedy choice reports a score
  `TSLA_ASSERT_IMPL(a_score_only_greedy, out_valid_o && !greedy_out, best_score_o == '0)

  // an override leaves the ambulance queued
  `TSLA_ASSERT_IMPL(a_override_amb, out_valid_o && override_out, ambulance_waiting_o && count_in_range)

endmodule

bind traffic_signal_lane_arbiter_top tsla_checker u_tsla_checker (.*);

`default_nettype wire

[tb/sv/tb.sv]
// self-checking testbench for traffic_signal_lane_arbiter_top
// depends on tsla_pkg and the arbiter rtl; a local lane model predicts each untyped transaction
// directed table first, then randomized phases under several register settings
module tb;
  import tsla_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 40;
  localparam int PhaseItems = 260;
  localparam int PhaseCount = 5;
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

  // per phase: register values (negative means random), decide share, ambulance odds
  localparam int PhaseBias [PhaseCount]   = '{0, 15, -1, 15, 3};
  localparam int PhaseShift [PhaseCount]  = '{0, 7, -1, 0, 1};
  localparam int PhaseDrain [PhaseCount]  = '{0, 32, -1, 0, 1};
  localparam int PhaseDecide [PhaseCount] = '{30, 50, 35, 40, 35};
  localparam int PhaseAmbOdds [PhaseCount] = '{10, 40, 12, 25, 12};

  typedef struct {
    item_t   req;
    int      reps;
    bit      typed;
    result_t want;
  } step_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic in_valid_i;
  logic in_stall_o;
  logic [1:0] command_i;
  logic [1:0] lane_i;
  logic is_ambulance_i;
  logic out_valid_o;
  logic out_stall_i;
  logic [1:0] green_lane_o;
  logic [2:0] outcome_o;
  logic [8:0] best_score_o;
  logic [5:0] green_count_o;
  logic ambulance_waiting_o;

  // lane model state and register shadows
  logic [CountW-1:0]     lane_fill [LaneCount];
  logic [QueueDepth-1:0] amb_flags [LaneCount];
  logic [AgeW-1:0]       wait_age [LaneCount];
  logic [LaneW-1:0]      green_sel;
  logic [CountW-1:0]     start_fill;
  logic [BiasW-1:0]      bias_cfg;
  logic [ShiftW-1:0]     shift_cfg;
  logic [DrainW-1:0]     drain_cfg;

  result_t   signal_due [$];
  result_t   due_now;
  step_row_t steps [24];
  int        mismatch_count = 0;
  int        cycle_count = 0;
  bit        tx_idle_on = 1'b1;
  bit        rx_idle_on = 1'b1;
  bit        long_hold_req = 1'b0;

  traffic_signal_lane_arbiter_top uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .command_i          (command_i),
    .lane_i             (lane_i),
    .is_ambulance_i     (is_ambulance_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .green_lane_o       (green_lane_o),
    .outcome_o          (outcome_o),
    .best_score_o       (best_score_o),
    .green_count_o      (green_count_o),
    .ambulance_waiting_o(ambulance_waiting_o)
  );

  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL traffic_signal_lane_arbiter_top");
      $finish;
    end
  end

  // applies one command to the lane model and returns the signal state it leaves
  function automatic result_t next_signal(item_t it);
    result_t r;
    int hit;
    int score;
    int top;
    int pick;
    r = '0;
    r.outcome = OutNoPass;
    case (it.command)
      CmdArrive: begin
        if (lane_fill[it.lane] >= QueueDepth) begin
          r.outcome = OutDropped;
        end else begin
          if (it.is_ambulance) amb_flags[it.lane][lane_fill[it.lane]] = 1'b1;
          lane_fill[it.lane] = lane_fill[it.lane] + 1'b1;
          r.outcome = OutAdded;
        end
      end
      CmdDecide: begin
        hit = -1;
        for (int i = LaneCount - 1; i >= 0; i--) begin
          if (amb_flags[i] != '0) hit = i;
        end
        if (hit >= 0) begin
          green_sel = LaneW'(hit);
          start_fill = lane_fill[hit];
          r.outcome = OutOverride;
        end else if (start_fill > drain_cfg && lane_fill[green_sel] > (start_fill >> 1)) begin
          r.outcome = OutHold;
        end else begin
          for (int i = 0; i < LaneCount; i++) begin
            if (i == green_sel) wait_age[i] = '0;
            else if (lane_fill[i] != 0 && wait_age[i] != AgeMax) wait_age[i] = wait_age[i] + 1'b1;
          end
          top = 0;
          pick = green_sel;
          for (int i = 0; i < LaneCount; i++) begin
            score = int'(lane_fill[i]) + int'(wait_age[i] >> shift_cfg);
            if (i == green_sel && lane_fill[i] != 0) score += int'(bias_cfg);
            if (i == 0 || score > top) begin
              top = score;
              pick = i;
            end
          end
          r.best_score = top[8:0];
          if (pick != green_sel) begin
            green_sel = LaneW'(pick);
            start_fill = lane_fill[pick];
            r.outcome = OutSwitched;
          end else begin
            r.outcome = OutContinued;
          end
        end
      end
      CmdPass: begin
        if (lane_fill[green_sel] != 0) begin
          amb_flags[green_sel] = amb_flags[green_sel] >> 1;
          lane_fill[green_sel] = lane_fill[green_sel] - 1'b1;
          r.outcome = OutPassed;
        end
      end
      default: ;
    endcase
    r.green_lane = green_sel;
    r.green_count = lane_fill[green_sel];
    for (int i = 0; i < LaneCount; i++) begin
      if (amb_flags[i] != '0) r.ambulance_waiting = 1'b1;
    end
    return r;
  endfunction

  // drives one transaction, waits for it to be taken, records what should come back
  task automatic offer(item_t it, bit typed, result_t want);
    result_t model;
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= it.command;
    lane_i <= it.lane;
    is_ambulance_i <= it.is_ambulance;
    do @(posedge clk_i); while (in_stall_o);
    model = next_signal(it);
    signal_due = {signal_due, (typed ? want : model)};
    @(negedge clk_i);
  endtask

  // write enable stays high across the register writes, index 3 is unused
  task automatic load_config(logic [5:0] b, logic [5:0] s, logic [5:0] d);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CfgBias;
    cfg_data_i <= b;
    @(negedge clk_i);
    cfg_index_i <= CfgShift;
    cfg_data_i <= s;
    @(negedge clk_i);
    cfg_index_i <= CfgDrain;
    cfg_data_i <= d;
    @(negedge clk_i);
    cfg_index_i <= CfgUnused;
    cfg_data_i <= 6'($urandom_range(0, 63));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    bias_cfg = b[BiasW-1:0];
    shift_cfg = s[ShiftW-1:0];
    drain_cfg = d;
  endtask

  task automatic check_field(string what, int want, int got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (signal_due.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected transaction, expected none, actual outcome %0d",
                 $time, outcome_o);
      end else begin
        due_now = signal_due.pop_front();
        check_field("green_lane", due_now.green_lane, green_lane_o);
        check_field("outcome", due_now.outcome, outcome_o);
        check_field("best_score", due_now.best_score, best_score_o);
        check_field("green_count", due_now.green_count, green_count_o);
        check_field("ambulance_waiting", due_now.ambulance_waiting, ambulance_waiting_o);
      end
    end
  end

  initial begin : receiver
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        // long back-pressure so the pipeline fills and stalls its input
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        out_stall_i <= 1'b0;
        long_hold_req = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 3)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    item_t it;
    int r;
    logic [5:0] cb;
    logic [5:0] cs;
    logic [5:0] cd;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CfgBias;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    command_i = CmdArrive;
    lane_i = 2'd0;
    is_ambulance_i = 1'b0;
    for (int i = 0; i < LaneCount; i++) begin
      lane_fill[i] = '0;
      amb_flags[i] = '0;
      wait_age[i] = '0;
    end
    green_sel = '0;
    start_fill = '0;
    bias_cfg = BiasReset;
    shift_cfg = ShiftReset;
    drain_cfg = DrainReset;

    // runs on reset register values
    steps = '{
      '{'{CmdPass, 2'd0, 1'b0}, 1, 1'b1, '{2'd0, OutNoPass, 9'd0, 6'd0, 1'b0}},
      '{'{CmdRsvd, 2'd3, 1'b1}, 1, 1'b1, '{2'd0, OutNoPass, 9'd0, 6'd0, 1'b0}},
      '{'{CmdDecide, 2'd2, 1'b1}, 1, 1'b1, '{2'd0, OutContinued, 9'd0, 6'd0, 1'b0}},
      '{'{CmdArrive, 2'd3, 1'b0}, 1, 1'b1, '{2'd0, OutAdded, 9'd0, 6'd0, 1'b0}},
      '{'{CmdArrive, 2'd3, 1'b1}, 1, 1'b1, '{2'd0, OutAdded, 9'd0, 6'd0, 1'b1}},
      '{'{CmdDecide, 2'd0, 1'b0}, 1, 1'b1, '{2'd3, OutOverride, 9'd0, 6'd2, 1'b1}},
      '{'{CmdPass, 2'd1, 1'b1}, 1, 1'b1, '{2'd3, OutPassed, 9'd0, 6'd1, 1'b1}},
      '{'{CmdPass, 2'd0, 1'b0}, 1, 1'b1, '{2'd3, OutPassed, 9'd0, 6'd0, 1'b0}},
      '{'{CmdPass, 2'd0, 1'b0}, 1, 1'b1, '{2'd3, OutNoPass, 9'd0, 6'd0, 1'b0}},
      // fill the south lane with ambulances up to the queue depth
      '{'{CmdArrive, 2'd1, 1'b1}, 32, 1'b0, '0},
      '{'{CmdArrive, 2'd1, 1'b0}, 1, 1'b1, '{2'd3, OutDropped, 9'd0, 6'd0, 1'b1}},
      '{'{CmdDecide, 2'd0, 1'b0}, 1, 1'b1, '{2'd1, OutOverride, 9'd0, 6'd32, 1'b1}},
      '{'{CmdArrive, 2'd2, 1'b0}, 4, 1'b0, '0},
      '{'{CmdPass, 2'd0, 1'b0}, 32, 1'b0, '0},
      '{'{CmdPass, 2'd0, 1'b0}, 1, 1'b1, '{2'd1, OutNoPass, 9'd0, 6'd0, 1'b0}},
      '{'{CmdDecide, 2'd0, 1'b0}, 1, 1'b1, '{2'd2, OutSwitched, 9'd4, 6'd4, 1'b0}},
      '{'{CmdPass, 2'd0, 1'b0}, 1, 1'b0, '0},
      '{'{CmdDecide, 2'd0, 1'b0}, 1, 1'b1, '{2'd2, OutHold, 9'd0, 6'd3, 1'b0}},
      '{'{CmdArrive, 2'd0, 1'b0}, 3, 1'b0, '0},
      '{'{CmdPass, 2'd0, 1'b0}, 1, 1'b0, '0},
      // starving north lane ages until it wins the greedy choice
      '{'{CmdDecide, 2'd0, 1'b0}, 12, 1'b0, '0},
      '{'{CmdArrive, 2'd2, 1'b1}, 1, 1'b0, '0},
      '{'{CmdArrive, 2'd0, 1'b1}, 1, 1'b0, '0},
      '{'{CmdDecide, 2'd3, 1'b1}, 1, 1'b0, '0}
    };

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (steps[i]) begin
      repeat (steps[i].reps) offer(steps[i].req, steps[i].typed, steps[i].want);
    end

    for (int ph = 0; ph < PhaseCount; ph++) begin
      in_valid_i <= 1'b0;
      while (signal_due.size() != 0) @(negedge clk_i);
      cb = PhaseBias[ph] < 0 ? 6'($urandom_range(0, 63)) : 6'(PhaseBias[ph]);
      cs = PhaseShift[ph] < 0 ? 6'($urandom_range(0, 63)) : 6'(PhaseShift[ph]);
      cd = PhaseDrain[ph] < 0 ? 6'($urandom_range(0, 32)) : 6'(PhaseDrain[ph]);
      load_config(cb, cs, cd);
      if (ph == 1) long_hold_req = 1'b1;
      if (ph == PhaseCount - 1) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      for (int k = 0; k < PhaseItems; k++) begin
        r = $urandom_range(0, 99);
        if (r < 40) it.command = CmdArrive;
        else if (r < 40 + PhaseDecide[ph]) it.command = CmdDecide;
        else if (r < 97) it.command = CmdPass;
        else it.command = CmdRsvd;
        it.lane = 2'($urandom_range(0, 3));
        it.is_ambulance = ($urandom_range(0, PhaseAmbOdds[ph] - 1) == 0);
        offer(it, 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (signal_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS traffic_signal_lane_arbiter_top");
    end else begin
      $display("FAIL traffic_signal_lane_arbiter_top");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/tsla_pkg.sv
rtl/tsla_arbiter.sv
rtl/tsla_step.sv
rtl/traffic_signal_lane_arbiter_top.sv
rtl/tsla_checker.sv
tb/sv/tb.sv
